### rtl/ssr_pkg.sv
// shared types and constants for the stream substring replace block
// operation word passed from the front end to the back end through the queue
// no dependencies
package ssr_pkg;

  // default sizes
  localparam int PATTERN_MAX_DEF = 8;
  localparam int ALIAS_MAX_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // config port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 4;
  localparam int BYTES_W     = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_BYTES  = 2'd1,
    REG_ALIAS_LENGTH   = 2'd2,
    REG_ALIAS_BYTES    = 2'd3
  } reg_index_t;

  // front end sequencer states
  typedef enum logic {
    FR_RUN,
    FR_FLUSH
  } front_state_t;

  // operation kinds carried to the back end
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_ALIAS,
    OP_MARK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        done;
  } ssr_op_t;

endpackage

### rtl/ssr_front.sv
// front end: accepts characters, keeps the match window, classifies each step
// pushes at most one operation word per cycle into the queue, none while it is full; uses ssr_pkg
module ssr_front #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int CNT_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [CNT_W-1:0]            plen,
  input  logic                        alen_zero,
  input  logic [ssr_pkg::BYTES_W-1:0] pattern_bytes,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_in,
  input  logic                        end_of_string,
  input  logic                        q_full,
  output logic                        q_push,
  output ssr_pkg::ssr_op_t            q_op
);
  import ssr_pkg::*;

  front_state_t     state;
  front_state_t     state_next;
  logic [7:0]       win [PATTERN_MAX];
  logic [7:0]       win_next [PATTERN_MAX];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             emitted;
  logic             emitted_next;
  logic             hold;
  logic             hold_next;
  logic [7:0]       hold_ch;
  logic             hold_eos;

  logic [7:0]       win_sh [PATTERN_MAX];
  logic [7:0]       w_ins [PATTERN_MAX];
  logic [7:0]       w_ins_sh [PATTERN_MAX];
  logic [7:0]       w_look [PATTERN_MAX];
  logic [CNT_W-1:0] cnt_ins;
  logic             ins_match;
  logic             look_match;
  logic             cur_valid;
  logic [7:0]       cur_ch;
  logic             cur_eos;
  logic             step_go;
  logic             word_end;
  logic             go_flush;

  // current word: the held one while a word needs further steps, else the input
  assign cur_valid = hold || in_valid;
  assign cur_ch    = hold ? hold_ch : char_in;
  assign cur_eos   = hold ? hold_eos : end_of_string;

  // candidate windows: shifted, with the new character, and the lookahead after a drop
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      win_sh[k] = (k < PATTERN_MAX - 1) ? win[(k + 1) % PATTERN_MAX] : win[k];
      w_ins[k]  = (CNT_W'(k) == count) ? cur_ch : win[k];
      w_look[k] = (CNT_W'(k) == plen - CNT_W'(1)) ? cur_ch : win_sh[k];
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      w_ins_sh[k] = (k < PATTERN_MAX - 1) ? w_ins[(k + 1) % PATTERN_MAX] : w_ins[k];
    end
  end

  assign cnt_ins = count + CNT_W'(1);

  // byte compare against the pattern, one lane per window slot
  always_comb begin
    ins_match  = 1'b1;
    look_match = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (CNT_W'(k) < plen) begin
        if (w_ins[k] != pattern_bytes[8*k +: 8]) begin
          ins_match = 1'b0;
        end
        if (w_look[k] != pattern_bytes[8*k +: 8]) begin
          look_match = 1'b0;
        end
      end
    end
  end

  assign step_go = cur_valid && !q_full;

  // step outputs: queue word, window update, end of the current word
  always_comb begin
    q_push     = 1'b0;
    q_op.kind  = OP_BYTE;
    q_op.data  = win[0];
    q_op.done  = 1'b0;
    word_end   = 1'b0;
    go_flush   = 1'b0;
    win_next   = win;
    count_next = count;
    if (step_go) begin
      case (state)
        FR_RUN: begin
          if (count >= plen) begin
            // pattern got shorter: drop oldest bytes before the new one enters
            q_push     = 1'b1;
            q_op.done  = cur_eos && (count == plen) && look_match && alen_zero;
            win_next   = win_sh;
            count_next = count - CNT_W'(1);
          end else if (cnt_ins == plen) begin
            if (ins_match) begin
              count_next = '0;
              word_end   = 1'b1;
              if (!alen_zero) begin
                q_push    = 1'b1;
                q_op.kind = OP_ALIAS;
                q_op.done = cur_eos;
              end else if (cur_eos && !emitted) begin
                q_push    = 1'b1;
                q_op.kind = OP_MARK;
                q_op.data = 8'd0;
                q_op.done = 1'b1;
              end
            end else begin
              q_push     = 1'b1;
              q_op.data  = w_ins[0];
              q_op.done  = cur_eos && (plen == CNT_W'(1));
              win_next   = w_ins_sh;
              count_next = plen - CNT_W'(1);
              if (cur_eos && plen != CNT_W'(1)) begin
                go_flush = 1'b1;
              end else begin
                word_end = 1'b1;
              end
            end
          end else begin
            win_next   = w_ins;
            count_next = cnt_ins;
            if (cur_eos) begin
              go_flush = 1'b1;
            end else begin
              word_end = 1'b1;
            end
          end
        end
        FR_FLUSH: begin
          // end of string: drain the window one byte per cycle while the queue is not full
          q_push     = 1'b1;
          q_op.done  = (count == CNT_W'(1));
          win_next   = win_sh;
          count_next = count - CNT_W'(1);
          word_end   = (count == CNT_W'(1));
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // input is taken on the first step of a word; a longer step holds it
  assign in_stall = hold || q_full;

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      FR_RUN: begin
        if (go_flush) begin
          state_next = FR_FLUSH;
        end
      end
      FR_FLUSH: begin
        if (word_end) begin
          state_next = FR_RUN;
        end
      end
      default: begin
        state_next = FR_RUN;
      end
    endcase
  end

  // tracks whether the current word already produced output
  always_comb begin
    emitted_next = emitted;
    if (word_end) begin
      emitted_next = 1'b0;
    end else if (q_push) begin
      emitted_next = 1'b1;
    end
  end

  // held word flag: set while a word needs more than one step
  always_comb begin
    hold_next = hold;
    if (word_end) begin
      hold_next = 1'b0;
    end else if (step_go) begin
      hold_next = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FR_RUN;
      count   <= '0;
      emitted <= 1'b0;
      hold    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      emitted <= emitted_next;
      hold    <= hold_next;
    end
  end

  // held word payload, captured at the accepting edge
  always_ff @(posedge clk) begin
    if (step_go && !hold) begin
      hold_ch  <= char_in;
      hold_eos <= end_of_string;
    end
  end

  // window storage
  always_ff @(posedge clk) begin
    win <= win_next;
  end

endmodule

### rtl/ssr_queue.sv
// short first-in first-out queue of operation words between front and back end
// uses ssr_pkg for the word type
module ssr_queue #(
  parameter int DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ssr_pkg::ssr_op_t push_op,
  output logic             full,
  input  logic             pop,
  output ssr_pkg::ssr_op_t head,
  output logic             empty
);
  import ssr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssr_op_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/ssr_back.sv
// back end: expands operation words into output words, alias bursts byte by byte
// owns the output register; uses ssr_pkg
module ssr_back #(
  parameter int ALIAS_MAX = ssr_pkg::ALIAS_MAX_DEF,
  parameter int ALEN_W    = $clog2(ALIAS_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ALEN_W-1:0]           alen,
  input  logic [ssr_pkg::BYTES_W-1:0] alias_bytes,
  input  logic                        q_empty,
  input  ssr_pkg::ssr_op_t            q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  char_out,
  output logic                        char_valid,
  output logic                        string_done
);
  import ssr_pkg::*;

  localparam int AIDX_W = (ALIAS_MAX > 1) ? $clog2(ALIAS_MAX) : 1;

  logic [AIDX_W-1:0] idx;
  logic              load;
  logic              alias_last;
  logic [7:0]        alias_byte;

  // output register takes a new word when empty or being drained
  assign load       = !q_empty && (!out_valid || !out_stall);
  assign alias_last = ((ALEN_W'(idx) + ALEN_W'(1)) == alen);
  assign alias_byte = alias_bytes[idx*8 +: 8];
  assign q_pop      = load && ((q_head.kind != OP_ALIAS) || alias_last);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // alias burst position
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load && q_head.kind == OP_ALIAS) begin
      idx <= alias_last ? '0 : idx + AIDX_W'(1);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      case (q_head.kind)
        OP_ALIAS: begin
          char_out    <= alias_byte;
          char_valid  <= 1'b1;
          string_done <= q_head.done && alias_last;
        end
        OP_MARK: begin
          char_out    <= 8'd0;
          char_valid  <= 1'b0;
          string_done <= 1'b1;
        end
        default: begin
          char_out    <= q_head.data;
          char_valid  <= 1'b1;
          string_done <= q_head.done;
        end
      endcase
    end
  end

endmodule

### rtl/stream_substring_replace_unit.sv
// stream substring replace: find-and-replace on a byte stream, non-overlapping
// path: the first result of a word goes through the queue and then the output register;
//   it comes later while the queue holds older words or when it comes from an end-of-string flush
// throughput: one character per cycle while the queue is not full and no word is held;
//   the back end emits an alias burst one byte per output word; a word holds the input
//   while it drops bytes from a shortened window or flushes them at end of string
// reset: synchronous, clears sequencer, queue, output valid and config registers (pattern
//   length goes to 1); window contents stay undefined until written
module stream_substring_replace_unit #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int ALIAS_MAX   = ssr_pkg::ALIAS_MAX_DEF,
  parameter int QUEUE_DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     char_in,
  input  logic                           end_of_string,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     char_out,
  output logic                           char_valid,
  output logic                           string_done
);
  import ssr_pkg::*;

  localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
  localparam int ALEN_W = $clog2(ALIAS_MAX + 1);

  logic [LEN_W-1:0]   pattern_length;
  logic [BYTES_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]   alias_length;
  logic [BYTES_W-1:0] alias_bytes;
  logic [CNT_W-1:0]   plen;
  logic [ALEN_W-1:0]  alen;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  ssr_op_t            q_in;
  ssr_op_t            q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      pattern_bytes  <= '0;
      alias_length   <= '0;
      alias_bytes    <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data[BYTES_W-1:0];
        REG_ALIAS_LENGTH:   alias_length   <= cfg_data[LEN_W-1:0];
        REG_ALIAS_BYTES:    alias_bytes    <= cfg_data[BYTES_W-1:0];
        default: begin
          pattern_length <= pattern_length;
        end
      endcase
    end
  end

  // effective lengths: pattern clamped to 1..max, alias saturated at max
  always_comb begin
    if (pattern_length == '0) begin
      plen = CNT_W'(1);
    end else if (pattern_length > LEN_W'(PATTERN_MAX)) begin
      plen = CNT_W'(PATTERN_MAX);
    end else begin
      plen = pattern_length[CNT_W-1:0];
    end
    if (alias_length > LEN_W'(ALIAS_MAX)) begin
      alen = ALEN_W'(ALIAS_MAX);
    end else begin
      alen = alias_length[ALEN_W-1:0];
    end
  end

  ssr_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .plen          (plen),
    .alen_zero     (alen == '0),
    .pattern_bytes (pattern_bytes),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (q_in)
  );

  ssr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  ssr_back #(
    .ALIAS_MAX (ALIAS_MAX),
    .ALEN_W    (ALEN_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .alen        (alen),
    .alias_bytes (alias_bytes),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_out    (char_out),
    .char_valid  (char_valid),
    .string_done (string_done)
  );

  // front never writes into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");

  // back never reads an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a word without a character is always a bare end marker
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |-> (string_done && char_out == 8'd0))
    else $error("bare word is not an end marker");

endmodule
